// ===== rtl/frg_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frg_pkg
// shared constants and types for the fraction reduction block
// ----------------------------------------------------------------------------
package frg_pkg;

  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EU_GO,
    ST_EU_WAIT,
    ST_RN_GO,
    ST_RN_WAIT,
    ST_RD_GO,
    ST_RD_WAIT,
    ST_OUT
  } frg_state_t;

  // request into the serial divider
  typedef struct packed {
    logic start;
  } frg_div_ctl_t;

  // status back from the serial divider
  typedef struct packed {
    logic busy;
    logic done;
  } frg_div_sts_t;

endpackage

// ===== rtl/frg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frg_in_if / frg_out_if
// valid/ready channels for fraction items and reduced results
// ----------------------------------------------------------------------------
interface frg_in_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] numerator;
  logic signed [WORD_BITS-1:0] denominator;
  modport source (output valid, numerator, denominator, input ready);
  modport sink (input valid, numerator, denominator, output ready);
endinterface

interface frg_out_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] reduced_numerator;
  logic signed [WORD_BITS-1:0] reduced_denominator;
  logic        [WORD_BITS-2:0] divisor;
  logic signed [WORD_BITS-1:0] coef_num;
  logic signed [WORD_BITS-1:0] coef_den;
  logic                        ok;
  modport source (output valid, reduced_numerator, reduced_denominator, divisor,
                  coef_num, coef_den, ok, input ready);
  modport sink (input valid, reduced_numerator, reduced_denominator, divisor,
                coef_num, coef_den, ok, output ready);
endinterface

// ===== rtl/fraction_reduce_ext_gcd.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_reduce_ext_gcd
// reduces a signed fraction by the gcd of its magnitudes and returns the
// bezout coefficients, using a bit-serial divider for every euclid step
// ----------------------------------------------------------------------------
// sequence: an input with a zero part is offered as a result in the cycle after
//   its transfer; otherwise the controller runs one divider pass per euclid
//   division, then one each for the reduced numerator and denominator
// flow: one item at a time, next input transfer at the earliest in the cycle after
//   the result transfer; set by the single bit-serial divider, one quotient bit per cycle
// reset: synchronous active-low rst_n clears the controller and the valid flag
// ----------------------------------------------------------------------------
module fraction_reduce_ext_gcd
  import frg_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  frg_in_if.sink    in_ch,
  frg_out_if.source out_ch
);

  localparam int MAX_STEPS = 2 * WORD_BITS;
  localparam int STEP_W    = $clog2(MAX_STEPS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(MAX_STEPS - 1);

  frg_state_t state_r, state_nxt;

  // euclid working set, all wrap modulo 2^WORD_BITS
  logic [WORD_BITS-1:0] x_r, y_r, sx_r, tx_r, sy_r, ty_r;
  logic [WORD_BITS-1:0] mag_n_r, mag_d_r;
  logic                 neg_n_r, neg_d_r, swapped_r;
  logic [STEP_W-1:0]    step_r;

  // result register
  logic [WORD_BITS-1:0] red_n_r, red_d_r, cn_r, cd_r;
  logic [WORD_BITS-2:0] gcd_r;
  logic                 ok_r;

  // input split
  logic [WORD_BITS-1:0] raw_n, raw_d, mag_n, mag_d;
  logic                 neg_n, neg_d, in_zero;
  logic                 in_xfer, out_xfer;

  // divider hookup
  frg_div_ctl_t         div_ctl;
  frg_div_sts_t         div_sts;
  logic [WORD_BITS-1:0] div_dividend, div_dvsr;
  logic [WORD_BITS-1:0] div_quo, div_rem, div_pa, div_pb;
  logic [WORD_BITS-1:0] cn_sel, cd_sel;

  assign raw_n   = in_ch.numerator;
  assign raw_d   = in_ch.denominator;
  assign neg_n   = raw_n[WORD_BITS-1];
  assign neg_d   = raw_d[WORD_BITS-1];
  assign mag_n   = neg_n ? (~raw_n + 1'b1) : raw_n;
  assign mag_d   = neg_d ? (~raw_d + 1'b1) : raw_d;
  assign in_zero = (raw_n == '0) || (raw_d == '0);
  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;

  // coefficient of each input, undoing the operand swap
  assign cn_sel = swapped_r ? tx_r : sx_r;
  assign cd_sel = swapped_r ? sx_r : tx_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = in_zero ? ST_OUT : ST_EU_GO;
      end
      ST_EU_GO:   state_nxt = ST_EU_WAIT;
      ST_EU_WAIT: begin
        if (div_sts.done) begin
          // stop on a zero remainder or when the step budget runs out
          if (div_rem == '0 || step_r == STEP_LAST) state_nxt = ST_RN_GO;
          else state_nxt = ST_EU_GO;
        end
      end
      ST_RN_GO:   state_nxt = ST_RN_WAIT;
      ST_RN_WAIT: begin
        if (div_sts.done) state_nxt = ST_RD_GO;
      end
      ST_RD_GO:   state_nxt = ST_RD_WAIT;
      ST_RD_WAIT: begin
        if (div_sts.done) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_xfer) state_nxt = ST_IDLE;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    in_ch.ready   = 1'b0;
    out_ch.valid  = 1'b0;
    div_ctl.start = 1'b0;
    div_dividend  = y_r;
    div_dvsr      = x_r;
    case (state_r)
      ST_IDLE:  in_ch.ready = 1'b1;
      ST_EU_GO: div_ctl.start = 1'b1;
      ST_RN_GO: begin
        div_ctl.start = 1'b1;
        div_dividend  = mag_n_r;
      end
      ST_RD_GO: begin
        div_ctl.start = 1'b1;
        div_dividend  = mag_d_r;
      end
      ST_OUT:   out_ch.valid = 1'b1;
      default: begin
        div_dividend = y_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        mag_n_r   <= mag_n;
        mag_d_r   <= mag_d;
        neg_n_r   <= neg_n;
        neg_d_r   <= neg_d;
        swapped_r <= (mag_d < mag_n);
        x_r       <= (mag_d < mag_n) ? mag_d : mag_n;
        y_r       <= (mag_d < mag_n) ? mag_n : mag_d;
        sx_r      <= WORD_BITS'(1);
        tx_r      <= '0;
        sy_r      <= '0;
        ty_r      <= WORD_BITS'(1);
        step_r    <= '0;
        // zero input passes straight to the result register
        red_n_r   <= raw_n;
        red_d_r   <= raw_d;
        gcd_r     <= '0;
        cn_r      <= '0;
        cd_r      <= '0;
        ok_r      <= 1'b0;
      end
      ST_EU_WAIT: begin
        if (div_sts.done && div_rem != '0) begin
          y_r    <= x_r;
          x_r    <= div_rem;
          sy_r   <= sx_r;
          ty_r   <= tx_r;
          sx_r   <= sy_r - div_pa;
          tx_r   <= ty_r - div_pb;
          step_r <= step_r + 1'b1;
        end
      end
      ST_RN_WAIT: begin
        if (div_sts.done) red_n_r <= neg_n_r ? (~div_quo + 1'b1) : div_quo;
      end
      ST_RD_WAIT: begin
        if (div_sts.done) begin
          red_d_r <= neg_d_r ? (~div_quo + 1'b1) : div_quo;
          gcd_r   <= x_r[WORD_BITS-2:0];
          cn_r    <= neg_n_r ? (~cn_sel + 1'b1) : cn_sel;
          cd_r    <= neg_d_r ? (~cd_sel + 1'b1) : cd_sel;
          ok_r    <= 1'b1;
        end
      end
      default: begin
        ok_r <= ok_r;
      end
    endcase
  end

  frg_div #(.WORD_BITS(WORD_BITS)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (div_ctl),
    .dividend  (div_dividend),
    .dvsr      (div_dvsr),
    .coef_a    (sx_r),
    .coef_b    (tx_r),
    .sts       (div_sts),
    .quotient  (div_quo),
    .remainder (div_rem),
    .prod_a    (div_pa),
    .prod_b    (div_pb)
  );

  assign out_ch.reduced_numerator   = red_n_r;
  assign out_ch.reduced_denominator = red_d_r;
  assign out_ch.divisor             = gcd_r;
  assign out_ch.coef_num            = cn_r;
  assign out_ch.coef_den            = cd_r;
  assign out_ch.ok                  = ok_r;

  // one item in flight: no intake while a result is offered
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !out_ch.valid)
    else $error("input taken while a result is pending");

  // euclid never divides by zero
  a_nonzero_gcd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EU_GO || state_r == ST_RN_GO || state_r == ST_RD_GO) |-> x_r != '0)
    else $error("division by zero operand");

  // the divider is only started when it is free
  a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");

endmodule

// ===== rtl/frg_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frg_div
// bit-serial restoring divider, one quotient bit per cycle, with two
// horner accumulators forming quotient times each coefficient
// ----------------------------------------------------------------------------
module frg_div
  import frg_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  frg_div_ctl_t         ctl,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] dvsr,
  input  logic [WORD_BITS-1:0] coef_a,
  input  logic [WORD_BITS-1:0] coef_b,
  output frg_div_sts_t         sts,
  output logic [WORD_BITS-1:0] quotient,
  output logic [WORD_BITS-1:0] remainder,
  output logic [WORD_BITS-1:0] prod_a,
  output logic [WORD_BITS-1:0] prod_b
);

  localparam int CNT_W = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_BITS - 1);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [WORD_BITS:0]   rem_r, rem_nxt;
  logic [WORD_BITS-1:0] quo_r, quo_nxt;
  logic [WORD_BITS-1:0] dvsr_r, dvsr_nxt;
  logic [WORD_BITS-1:0] ca_r, ca_nxt, cb_r, cb_nxt;
  logic [WORD_BITS-1:0] pa_r, pa_nxt, pb_r, pb_nxt;
  logic [WORD_BITS:0]   trial;
  logic                 qbit;

  always_comb begin
    trial    = {rem_r[WORD_BITS-1:0], quo_r[WORD_BITS-1]};
    qbit     = (trial >= {1'b0, dvsr_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvsr_nxt = dvsr_r;
    ca_nxt   = ca_r;
    cb_nxt   = cb_r;
    pa_nxt   = pa_r;
    pb_nxt   = pb_r;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvsr_nxt = dvsr;
      ca_nxt   = coef_a;
      cb_nxt   = coef_b;
      pa_nxt   = '0;
      pb_nxt   = '0;
    end else if (busy_r) begin
      rem_nxt = qbit ? (trial - {1'b0, dvsr_r}) : trial;
      quo_nxt = {quo_r[WORD_BITS-2:0], qbit};
      pa_nxt  = {pa_r[WORD_BITS-2:0], 1'b0} + (qbit ? ca_r : '0);
      pb_nxt  = {pb_r[WORD_BITS-2:0], 1'b0} + (qbit ? cb_r : '0);
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dvsr_r <= dvsr_nxt;
    ca_r   <= ca_nxt;
    cb_r   <= cb_nxt;
    pa_r   <= pa_nxt;
    pb_r   <= pb_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r[WORD_BITS-1:0];
  assign prod_a    = pa_r;
  assign prod_b    = pb_r;

  // the remainder never reaches the divisor once a division ends
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < {1'b0, dvsr_r}))
    else $error("divider remainder not below divisor");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a division in flight");

endmodule

// ===== test/fraction_reduce_ext_gcd_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fraction_reduce_ext_gcd_tb
// drives signed fractions into the gcd reducer under random idling on both
// channels and checks every result field against an in-bench euclid predictor
// ----------------------------------------------------------------------------
module fraction_reduce_ext_gcd_tb;
  import frg_pkg::*;

  localparam int WB = 32;
  localparam int STALL_LIMIT = 20000;

  typedef struct packed {
    logic signed [WB-1:0] num;
    logic signed [WB-1:0] den;
  } frac_t;

  typedef struct packed {
    logic signed [WB-1:0] rnum;
    logic signed [WB-1:0] rden;
    logic [WB-2:0]        gcd;
    logic signed [WB-1:0] cnum;
    logic signed [WB-1:0] cden;
    logic                 ok;
  } reduced_t;

  logic clk;
  logic rst_n;

  frg_in_if  #(.WORD_BITS(WB)) in_ch ();
  frg_out_if #(.WORD_BITS(WB)) out_ch ();

  fraction_reduce_ext_gcd #(.WORD_BITS(WB)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  frac_t    pending_fracs[$];
  reduced_t expected_reductions[$];
  int       send_idle_pct;
  int       recv_idle_pct;
  bit       stim_done;
  int       errors;
  int       quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // euclid on magnitudes, smaller operand first, tracking the bezout pair
  function automatic reduced_t reduce_fraction(frac_t f);
    reduced_t r;
    logic [WB-1:0] mag_n, mag_d, x, y, q, rem, g, sx, tx, sy, ty, nsx, ntx, cn, cd;
    logic neg_n, neg_d, swapped;
    neg_n = f.num[WB-1];
    neg_d = f.den[WB-1];
    mag_n = neg_n ? -f.num : f.num;
    mag_d = neg_d ? -f.den : f.den;
    if (mag_n == 0 || mag_d == 0) begin
      r = '0;
      r.rnum = f.num;
      r.rden = f.den;
      return r;
    end
    swapped = mag_d < mag_n;
    x = swapped ? mag_d : mag_n;
    y = swapped ? mag_n : mag_d;
    sx = 1; tx = 0; sy = 0; ty = 1;
    for (int i = 0; i < 2 * WB; i++) begin
      q = y / x;
      rem = y - q * x;
      if (rem == 0) break;
      nsx = sy - q * sx;
      ntx = ty - q * tx;
      sy = sx; ty = tx; y = x;
      sx = nsx; tx = ntx; x = rem;
    end
    g = x;
    cn = swapped ? tx : sx;
    cd = swapped ? sx : tx;
    r.rnum = neg_n ? -(mag_n / g) : (mag_n / g);
    r.rden = neg_d ? -(mag_d / g) : (mag_d / g);
    r.gcd  = g[WB-2:0];
    r.cnum = neg_n ? -cn : cn;
    r.cden = neg_d ? -cd : cd;
    r.ok   = 1'b1;
    return r;
  endfunction

  function automatic logic [WB-1:0] rand_word();
    logic [WB-1:0] w;
    w = $urandom();
    case ($urandom_range(0, 5))
      0: w = w >> $urandom_range(0, WB - 1);
      1: w = $urandom_range(0, 20);
      2: w = -$urandom_range(0, 20);
      default: ;
    endcase
    return w;
  endfunction

  // fraction that in one draw of three gets a planted common factor so gcd is often large
  function automatic frac_t rand_frac();
    frac_t f;
    logic [WB-1:0] k;
    f.num = rand_word();
    f.den = rand_word();
    if ($urandom_range(0, 2) == 0) begin
      k = $urandom_range(1, 1 << $urandom_range(1, 15));
      f.num = (f.num >>> 16) * k;
      f.den = (f.den >>> 16) * k;
    end
    return f;
  endfunction

  function automatic frac_t mk(logic [WB-1:0] n, logic [WB-1:0] d);
    frac_t f;
    f.num = n;
    f.den = d;
    return f;
  endfunction

  task automatic wait_drained();
    while (pending_fracs.size() != 0 || expected_reductions.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    logic [WB-1:0] maxp, minn;
    maxp = {1'b0, {(WB-1){1'b1}}};
    minn = {1'b1, {(WB-1){1'b0}}};
    rst_n = 1'b0;
    stim_done = 1'b0;
    errors = 0;
    send_idle_pct = 35;
    recv_idle_pct = 69;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zeros, extremes, equal magnitudes, coprime and most negative
    pending_fracs.push_back(mk(0, 0));
    pending_fracs.push_back(mk(0, 7));
    pending_fracs.push_back(mk(-5, 0));
    pending_fracs.push_back(mk(maxp, 0));
    pending_fracs.push_back(mk(maxp, maxp));
    pending_fracs.push_back(mk(maxp, -maxp));
    pending_fracs.push_back(mk(-maxp, maxp - 1));
    pending_fracs.push_back(mk(1, maxp));
    pending_fracs.push_back(mk(-1, -1));
    pending_fracs.push_back(mk(6, -6));
    pending_fracs.push_back(mk(12, 18));
    pending_fracs.push_back(mk(-18, 12));
    pending_fracs.push_back(mk(1836311903, 1134903170));
    pending_fracs.push_back(mk(-1134903170, 1836311903));
    pending_fracs.push_back(mk(minn, minn));
    pending_fracs.push_back(mk(minn, 4));
    pending_fracs.push_back(mk(3, minn));
    pending_fracs.push_back(mk(minn, 0));
    pending_fracs.push_back(mk(32'h5555_5555, 32'hAAAA_AAAA));

    for (int ph = 0; ph < 3; ph++) begin
      for (int i = 0; i < 160; i++) pending_fracs.push_back(rand_frac());
      wait_drained();
      send_idle_pct = (ph == 0) ? 69 : 0;
      recv_idle_pct = (ph == 0) ? 35 : 0;
    end
    stim_done = 1'b1;
  end

  // driver: one nonblocking update per edge
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.numerator <= '0;
      in_ch.denominator <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) begin
        frac_t f;
        f = pending_fracs.pop_front();
        expected_reductions.push_back(reduce_fraction(f));
      end
      if (pending_fracs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.numerator <= pending_fracs[0].num;
        in_ch.denominator <= pending_fracs[0].den;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // the head of pending_fracs is what sits on the bus until its transfer
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitor: compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_reductions.size() == 0) begin
        $error("unexpected result transfer");
        errors++;
      end else begin
        reduced_t e;
        e = expected_reductions.pop_front();
        if (out_ch.reduced_numerator !== e.rnum) begin
          $error("reduced_numerator exp %0d got %0d", e.rnum, out_ch.reduced_numerator);
          errors++;
        end
        if (out_ch.reduced_denominator !== e.rden) begin
          $error("reduced_denominator exp %0d got %0d", e.rden, out_ch.reduced_denominator);
          errors++;
        end
        if (out_ch.divisor !== e.gcd) begin
          $error("divisor exp %0d got %0d", e.gcd, out_ch.divisor);
          errors++;
        end
        if (out_ch.coef_num !== e.cnum) begin
          $error("coef_num exp %0d got %0d", e.cnum, out_ch.coef_num);
          errors++;
        end
        if (out_ch.coef_den !== e.cden) begin
          $error("coef_den exp %0d got %0d", e.cden, out_ch.coef_den);
          errors++;
        end
        if (out_ch.ok !== e.ok) begin
          $error("ok exp %0d got %0d", e.ok, out_ch.ok);
          errors++;
        end
      end
    end
  end

  // watchdog and end of run
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (stim_done);
    repeat (2000) @(posedge clk);
    if (errors == 0 && expected_reductions.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== fraction_reduce_ext_gcd.f =====
rtl/frg_pkg.sv
rtl/frg_if.sv
rtl/frg_div.sv
rtl/fraction_reduce_ext_gcd.sv
test/fraction_reduce_ext_gcd_tb.sv
